/* rtl/core/bxds_pkg.sv */
// Shared types, widths and register codes of the box-average RGB downscaler.
// Used by every module under rtl/core; depends on nothing.
package bxds_pkg;

    localparam int CHAN_W = 8;
    localparam int NUM_CHAN = 3;
    localparam int CH_RED = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 0;

    localparam int WIDTH_W = 11;
    localparam int HEIGHT_W = 12;
    localparam int FACTOR_W = 5;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

    localparam int RST_FRAME_WIDTH = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int RST_SCALE_FACTOR = 2;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_FACTOR = 16;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic first;
        logic emit;
        logic row_end;
        logic frame_end;
    } op_flags_t;

    function automatic int col_w(input int max_width);
        return (max_width > 2048) ? WIDTH_W : $clog2(max_width);
    endfunction

    function automatic int fact_w(input int max_factor);
        return $clog2(max_factor + 1);
    endfunction

    function automatic int sub_w(input int max_factor);
        return $clog2(max_factor);
    endfunction

    function automatic int area_w(input int max_factor);
        return 2 * $clog2(max_factor + 1);
    endfunction

    function automatic int sum_w(input int max_factor);
        return CHAN_W + 2 * $clog2(max_factor);
    endfunction

endpackage

/* rtl/core/bxds_front.sv */
// Front end: configuration registers, block limit setup and raster position tracking.
// Classifies each transfer and pushes block work to the queue. Depends on bxds_pkg.
module bxds_front #(
    parameter int MAX_WIDTH = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bxds_pkg::DEF_MAX_FACTOR
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write_en,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [bxds_pkg::CFG_DATA_W-1:0]              cfg_data,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  bxds_pkg::rgb_t                               pixel,
    output logic                                         q_push,
    input  logic                                         q_full,
    output bxds_pkg::op_flags_t                          q_flags,
    output logic [bxds_pkg::col_w(MAX_WIDTH)-1:0]        q_addr,
    output bxds_pkg::rgb_t                               q_pixel,
    output logic [bxds_pkg::area_w(MAX_FACTOR)-1:0]      area
);
    import bxds_pkg::*;

    localparam int COL_W = col_w(MAX_WIDTH);
    localparam int FACT_W = fact_w(MAX_FACTOR);
    localparam int FW1 = FACT_W + 1;
    localparam int SUB_W = sub_w(MAX_FACTOR);
    localparam int AREA_W = area_w(MAX_FACTOR);
    localparam int DIM_W = HEIGHT_W;
    localparam int POS_W = HEIGHT_W + 1;
    localparam int STEP_W = $clog2(DIM_W);

    typedef enum logic [1:0] {F_LOAD, F_RUN, F_READY} setup_state_t;

    setup_state_t          setup_state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [WIDTH_W-1:0]    frame_width_reg;
    logic [HEIGHT_W-1:0]   frame_height_reg;
    logic [FACTOR_W-1:0]   scale_factor_reg;

    logic [COL_W-1:0]      src_col_reg, src_col_next;
    logic [HEIGHT_W-1:0]   src_row_reg, src_row_next;
    logic [SUB_W-1:0]      sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]      sub_row_reg, sub_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;

    logic [DIM_W-1:0]      div_w_reg, div_h_reg;
    logic [FACT_W-1:0]     rem_w_reg, rem_h_reg;
    logic [WIDTH_W-1:0]    dw_reg;
    logic [WIDTH_W-1:0]    col_limit_reg;
    logic [HEIGHT_W-1:0]   row_limit_reg;
    logic [AREA_W-1:0]     area_reg;

    logic [WIDTH_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0]   h_eff;
    logic [FACT_W-1:0]     f_eff;

    logic [FW1-1:0]        tw, th;
    logic                  ge_w, ge_h;
    logic [FACT_W-1:0]     rem_w_next, rem_h_next;
    logic [DIM_W-1:0]      quo_w_next, quo_h_next;
    logic                  last_step;

    logic                  accept;
    logic                  col_active, row_active;
    logic                  col_wrap, row_wrap;
    logic                  sub_col_wrap, sub_row_wrap;
    logic                  blk_first, blk_last;
    logic                  row_end_c, frame_end_c;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width_reg;
        end

        h_eff = (frame_height_reg == '0) ? HEIGHT_W'(1) : frame_height_reg;

        if (scale_factor_reg == '0)
        begin
            f_eff = FACT_W'(1);
        end
        else if (int'(scale_factor_reg) > MAX_FACTOR)
        begin
            f_eff = FACT_W'(MAX_FACTOR);
        end
        else
        begin
            f_eff = FACT_W'(scale_factor_reg);
        end
    end

    always_comb
    begin
        tw = {rem_w_reg, div_w_reg[DIM_W-1]};
        th = {rem_h_reg, div_h_reg[DIM_W-1]};
        ge_w = tw >= FW1'(f_eff);
        ge_h = th >= FW1'(f_eff);
        rem_w_next = ge_w ? FACT_W'(tw - FW1'(f_eff)) : tw[FACT_W-1:0];
        rem_h_next = ge_h ? FACT_W'(th - FW1'(f_eff)) : th[FACT_W-1:0];
        quo_w_next = {div_w_reg[DIM_W-2:0], ge_w};
        quo_h_next = {div_h_reg[DIM_W-2:0], ge_h};
        last_step = step_reg == STEP_W'(DIM_W - 1);
    end

    always_comb
    begin
        col_active = POS_W'(src_col_reg) < POS_W'(col_limit_reg);
        row_active = POS_W'(src_row_reg) < POS_W'(row_limit_reg);
        col_wrap = POS_W'(src_col_reg) + POS_W'(1) >= POS_W'(w_eff);
        row_wrap = POS_W'(src_row_reg) + POS_W'(1) >= POS_W'(h_eff);
        sub_col_wrap = FW1'(sub_col_reg) + FW1'(1) >= FW1'(f_eff);
        sub_row_wrap = FW1'(sub_row_reg) + FW1'(1) >= FW1'(f_eff);
        blk_first = (sub_col_reg == '0) && (sub_row_reg == '0);
        blk_last = (FACT_W'(sub_col_reg) >= f_eff - FACT_W'(1))
                && (FACT_W'(sub_row_reg) >= f_eff - FACT_W'(1));
        row_end_c = POS_W'(out_col_reg) + POS_W'(1) >= POS_W'(dw_reg);
        frame_end_c = row_end_c
                && (POS_W'(src_row_reg) + POS_W'(1) >= POS_W'(row_limit_reg));
    end

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        out_col_next = out_col_reg;
        if (col_wrap)
        begin
            src_col_next = '0;
            sub_col_next = '0;
            out_col_next = '0;
            if (row_wrap)
            begin
                src_row_next = '0;
                sub_row_next = '0;
            end
            else
            begin
                if (row_active)
                begin
                    sub_row_next = sub_row_wrap ? '0 : sub_row_reg + SUB_W'(1);
                end
                src_row_next = src_row_reg + HEIGHT_W'(1);
            end
        end
        else
        begin
            if (col_active)
            begin
                if (sub_col_wrap)
                begin
                    sub_col_next = '0;
                    out_col_next = out_col_reg + COL_W'(1);
                end
                else
                begin
                    sub_col_next = sub_col_reg + SUB_W'(1);
                end
            end
            src_col_next = src_col_reg + COL_W'(1);
        end
    end

    assign in_stall = (setup_state_reg != F_READY) || q_full;
    assign accept = in_valid && !in_stall;
    assign q_push = accept && col_active && row_active;
    assign q_flags.first = blk_first;
    assign q_flags.emit = blk_last;
    assign q_flags.row_end = row_end_c;
    assign q_flags.frame_end = frame_end_c;
    assign q_addr = out_col_reg;
    assign q_pixel = pixel;
    assign area = area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_state_reg <= F_LOAD;
            step_reg <= '0;
            frame_width_reg <= WIDTH_W'(RST_FRAME_WIDTH);
            frame_height_reg <= HEIGHT_W'(RST_FRAME_HEIGHT);
            scale_factor_reg <= FACTOR_W'(RST_SCALE_FACTOR);
            src_col_reg <= '0;
            src_row_reg <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg <= cfg_data[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_W-1:0];
                    REG_SCALE_FACTOR: scale_factor_reg <= cfg_data[FACTOR_W-1:0];
                    default:          ;
                endcase
                setup_state_reg <= F_LOAD;
            end
            else
            begin
                case (setup_state_reg)
                    F_LOAD:
                    begin
                        step_reg <= '0;
                        setup_state_reg <= F_RUN;
                    end
                    F_RUN:
                    begin
                        if (last_step)
                        begin
                            setup_state_reg <= F_READY;
                        end
                        else
                        begin
                            step_reg <= step_reg + STEP_W'(1);
                        end
                    end
                    F_READY: ;
                    default: setup_state_reg <= F_LOAD;
                endcase
            end

            if (accept)
            begin
                src_col_reg <= src_col_next;
                src_row_reg <= src_row_next;
                sub_col_reg <= sub_col_next;
                sub_row_reg <= sub_row_next;
                out_col_reg <= out_col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (setup_state_reg)
            F_LOAD:
            begin
                div_w_reg <= DIM_W'(w_eff);
                div_h_reg <= h_eff;
                rem_w_reg <= '0;
                rem_h_reg <= '0;
                area_reg <= AREA_W'(f_eff) * AREA_W'(f_eff);
            end
            F_RUN:
            begin
                div_w_reg <= quo_w_next;
                div_h_reg <= quo_h_next;
                rem_w_reg <= rem_w_next;
                rem_h_reg <= rem_h_next;
                if (last_step)
                begin
                    dw_reg <= WIDTH_W'(quo_w_next);
                    col_limit_reg <= w_eff - WIDTH_W'(rem_w_next);
                    row_limit_reg <= h_eff - HEIGHT_W'(rem_h_next);
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/bxds_queue.sv */
// Short work queue between the front end and the accumulate/divide back end.
// Holds block flags, output column and pixel. Depends on bxds_pkg.
module bxds_queue #(
    parameter int ADDR_W = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  bxds_pkg::op_flags_t  in_flags,
    input  logic [ADDR_W-1:0]    in_addr,
    input  bxds_pkg::rgb_t       in_pixel,
    input  logic                 pop,
    output logic                 empty,
    output bxds_pkg::op_flags_t  out_flags,
    output logic [ADDR_W-1:0]    out_addr,
    output bxds_pkg::rgb_t       out_pixel
);
    import bxds_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_flags_t          flags_reg [QUEUE_DEPTH];
    logic [ADDR_W-1:0]  addr_reg [QUEUE_DEPTH];
    rgb_t               pixel_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign full = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign out_flags = flags_reg[rd_ptr_reg];
    assign out_addr = addr_reg[rd_ptr_reg];
    assign out_pixel = pixel_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_reg[wr_ptr_reg] <= in_flags;
            addr_reg[wr_ptr_reg] <= in_addr;
            pixel_reg[wr_ptr_reg] <= in_pixel;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !empty)
        else $error("pushed entry lost");

endmodule

/* rtl/core/bxds_back.sv */
// Back end: per-column sum store, read-modify-write accumulate and block average divider.
// Drives the result channel. Depends on bxds_pkg.
module bxds_back #(
    parameter int MAX_WIDTH = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bxds_pkg::DEF_MAX_FACTOR
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         empty,
    output logic                                         pop,
    input  bxds_pkg::op_flags_t                          flags,
    input  logic [bxds_pkg::col_w(MAX_WIDTH)-1:0]        addr,
    input  bxds_pkg::rgb_t                               pixel,
    input  logic [bxds_pkg::area_w(MAX_FACTOR)-1:0]      area,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic [bxds_pkg::CHAN_W-1:0]                  red_out,
    output logic [bxds_pkg::CHAN_W-1:0]                  green_out,
    output logic [bxds_pkg::CHAN_W-1:0]                  blue_out,
    output logic                                         row_end,
    output logic                                         frame_end
);
    import bxds_pkg::*;

    localparam int COL_W = col_w(MAX_WIDTH);
    localparam int AREA_W = area_w(MAX_FACTOR);
    localparam int SUM_W = sum_w(MAX_FACTOR);
    localparam int STEP_W = $clog2(SUM_W);

    typedef logic [NUM_CHAN-1:0][SUM_W-1:0] sum_vec_t;
    typedef enum logic [1:0] {B_IDLE, B_ACC, B_DIV, B_OUT} back_state_t;

    back_state_t                          state_reg;
    logic [STEP_W-1:0]                    step_reg;

    sum_vec_t                             sums_mem [MAX_WIDTH];
    sum_vec_t                             rd_data_reg;

    op_flags_t                            flags_reg;
    logic [COL_W-1:0]                     addr_reg;
    rgb_t                                 pix_reg;

    sum_vec_t                             quo_reg, quo_next;
    logic [NUM_CHAN-1:0][AREA_W-1:0]      rem_reg, rem_next;

    logic [NUM_CHAN-1:0][CHAN_W-1:0]      pix_chan;
    sum_vec_t                             new_sum;
    logic [NUM_CHAN-1:0][AREA_W:0]        trial;
    logic [NUM_CHAN-1:0]                  ge;
    logic                                 last_step;

    assign pop = (state_reg == B_IDLE) && !empty;
    assign pix_chan = pix_reg;
    assign last_step = step_reg == STEP_W'(SUM_W - 1);

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            new_sum[c] = flags_reg.first ? SUM_W'(pix_chan[c])
                                         : rd_data_reg[c] + SUM_W'(pix_chan[c]);
            trial[c] = {rem_reg[c], quo_reg[c][SUM_W-1]};
            ge[c] = trial[c] >= (AREA_W + 1)'(area);
            rem_next[c] = ge[c] ? AREA_W'(trial[c] - (AREA_W + 1)'(area))
                                : trial[c][AREA_W-1:0];
            quo_next[c] = {quo_reg[c][SUM_W-2:0], ge[c]};
        end
    end

    assign out_valid = state_reg == B_OUT;
    assign red_out = quo_reg[CH_RED][CHAN_W-1:0];
    assign green_out = quo_reg[CH_GREEN][CHAN_W-1:0];
    assign blue_out = quo_reg[CH_BLUE][CHAN_W-1:0];
    assign row_end = flags_reg.row_end;
    assign frame_end = flags_reg.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        state_reg <= B_ACC;
                    end
                end
                B_ACC:
                begin
                    step_reg <= '0;
                    state_reg <= flags_reg.emit ? B_DIV : B_IDLE;
                end
                B_DIV:
                begin
                    if (last_step)
                    begin
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                B_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            flags_reg <= flags;
            addr_reg <= addr;
            pix_reg <= pixel;
        end
        if (state_reg == B_ACC && flags_reg.emit)
        begin
            quo_reg <= new_sum;
            rem_reg <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= sums_mem[addr];
        end
        if (state_reg == B_ACC)
        begin
            sums_mem[addr_reg] <= new_sum;
        end
    end

    a_pop_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == B_ACC)
        else $error("popped work not accumulated next cycle");

    a_area_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> area != '0)
        else $error("divide by zero block area");

    a_full_divide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == B_DIV && $past(last_step))
        else $error("result shown before divide finished");

endmodule

/* rtl/core/box_average_downscale_rgb.sv */
// Box-average integer downscaler for RGB888 raster streams: top level.
// Instantiates bxds_front, bxds_queue and bxds_back; depends on bxds_pkg.
//
// Pixels arrive in raster order and every factor x factor block yields one pixel
// holding the truncated per-channel mean. After reset, and after any register write,
// the block holds in_stall high while the front end works out the active width,
// active height and output row length with a bit-serial divider. A pixel outside
// the active area is taken without entering the queue. An active pixel is handled
// in the back end as a read of the column sum store, then an add and write back;
// the pixel that closes a block then has its channel sums divided by the block
// area in a restoring divider, and the result is held until out_stall is low. A
// two-entry queue lets the front end take pixels while the back end is busy or its
// result is held by out_stall.
module box_average_downscale_rgb #(
    parameter int MAX_WIDTH = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bxds_pkg::DEF_MAX_FACTOR
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bxds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bxds_pkg::CHAN_W-1:0]       red_in,
    input  logic [bxds_pkg::CHAN_W-1:0]       green_in,
    input  logic [bxds_pkg::CHAN_W-1:0]       blue_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bxds_pkg::CHAN_W-1:0]       red_out,
    output logic [bxds_pkg::CHAN_W-1:0]       green_out,
    output logic [bxds_pkg::CHAN_W-1:0]       blue_out,
    output logic                              row_end,
    output logic                              frame_end
);
    import bxds_pkg::*;

    localparam int COL_W = col_w(MAX_WIDTH);
    localparam int AREA_W = area_w(MAX_FACTOR);

    rgb_t               in_pixel;
    logic               q_push, q_full, q_pop, q_empty;
    op_flags_t          push_flags, pop_flags;
    logic [COL_W-1:0]   push_addr, pop_addr;
    rgb_t               push_pixel, pop_pixel;
    logic [AREA_W-1:0]  area;

    assign in_pixel.red = red_in;
    assign in_pixel.green = green_in;
    assign in_pixel.blue = blue_in;

    bxds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (in_pixel),
        .q_push       (q_push),
        .q_full       (q_full),
        .q_flags      (push_flags),
        .q_addr       (push_addr),
        .q_pixel      (push_pixel),
        .area         (area)
    );

    bxds_queue #(
        .ADDR_W (COL_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .full      (q_full),
        .in_flags  (push_flags),
        .in_addr   (push_addr),
        .in_pixel  (push_pixel),
        .pop       (q_pop),
        .empty     (q_empty),
        .out_flags (pop_flags),
        .out_addr  (pop_addr),
        .out_pixel (pop_pixel)
    );

    bxds_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .pop       (q_pop),
        .flags     (pop_flags),
        .addr      (pop_addr),
        .pixel     (pop_pixel),
        .area      (area),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

endmodule
